// ===== rtl/msub_pkg.sv =====
// Shared constants for the maximum subrectangle sum block.
`default_nettype none
package msub_pkg;
  localparam int MAX_ROWS_DEF   = 64;
  localparam int MAX_COLS_DEF   = 64;
  localparam int VALUE_BITS_DEF = 16;
  localparam int CFG_BITS       = 7;
  localparam int CELL_BITS      = 16;
  localparam int SUM_BITS       = 27;
  localparam int IDX_ROW_COUNT  = 0;
  localparam int IDX_COL_COUNT  = 1;
  localparam int REG_ROW_COUNT_RESET = 64;
  localparam int REG_COL_COUNT_RESET = 64;
endpackage
`default_nettype wire

// ===== rtl/msub_front.sv =====
// Front end: accepts cells, writes the grid store, queues search requests.
`default_nettype none
module msub_front #(
  parameter int MAX_ROWS   = msub_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = msub_pkg::MAX_COLS_DEF,
  parameter int VALUE_BITS = msub_pkg::VALUE_BITS_DEF,
  parameter int CAP        = MAX_ROWS * MAX_COLS,
  parameter int AW         = (CAP > 1) ? $clog2(CAP) : 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_push,
  output logic                                   in_full,
  input  wire logic signed [msub_pkg::CELL_BITS-1:0] in_cell_value,
  input  wire logic                              in_last_cell,
  output logic                                   wr_en,
  output logic [AW-1:0]                          wr_addr,
  output logic signed [VALUE_BITS-1:0]           wr_data,
  output logic                                   req_valid,
  input  wire logic                              req_take
);
  import msub_pkg::*;
  localparam int PW = $clog2(CAP + 1);
  logic [PW-1:0] ptr_r, ptr_nxt;
  logic req_r, req_nxt;
  logic acc;

  // one-entry request queue; hold input until the search result transfers
  assign in_full   = req_r;
  assign acc       = in_push && !in_full;
  assign req_valid = req_r;
  assign wr_en     = acc && (ptr_r < PW'(CAP));
  assign wr_addr   = ptr_r[AW-1:0];
  assign wr_data   = VALUE_BITS'(in_cell_value);

  always_comb begin
    ptr_nxt = ptr_r;
    req_nxt = req_r && !req_take;
    if (acc) begin
      if (in_last_cell) begin
        ptr_nxt = '0;
        req_nxt = 1'b1;
      end else if (ptr_r < PW'(CAP)) begin
        ptr_nxt = ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
      req_r <= 1'b0;
    end else begin
      ptr_r <= ptr_nxt;
      req_r <= req_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/msub_back.sv =====
// Back end: grid memory and the row-pair column scan.
`default_nettype none
module msub_back #(
  parameter int MAX_ROWS   = msub_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = msub_pkg::MAX_COLS_DEF,
  parameter int VALUE_BITS = msub_pkg::VALUE_BITS_DEF,
  parameter int CAP        = MAX_ROWS * MAX_COLS,
  parameter int AW         = (CAP > 1) ? $clog2(CAP) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        wr_en,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic signed [VALUE_BITS-1:0] wr_data,
  input  wire logic                        req_valid,
  output logic                             req_take,
  input  wire logic [msub_pkg::CFG_BITS-1:0] rows_cfg,
  input  wire logic [msub_pkg::CFG_BITS-1:0] cols_cfg,
  output logic                             res_valid,
  output logic [msub_pkg::SUM_BITS-1:0]    res_sum,
  input  wire logic                        res_take
);
  import msub_pkg::*;
  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int CW = $clog2(MAX_COLS + 1);
  localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int LW = $clog2(MAX_ROWS * MAX_COLS + 1) + 1;
  localparam int BW = VALUE_BITS + $clog2(MAX_ROWS * MAX_COLS + 1) + 1;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_ACC, S_NEXT, S_DONE} st_t;
  st_t st_r;

  logic signed [VALUE_BITS-1:0] mem [CAP];
  logic signed [VALUE_BITS-1:0] rd_r;
  logic signed [BW-1:0] colacc [MAX_COLS];
  logic signed [BW-1:0] acc_rd_r;
  logic signed [BW-1:0] run_r, best_r, col_s, run_s;
  logic [RW-1:0] rows_r, top_r, bot_r;
  logic [CW-1:0] cols_r, c_r;
  logic [LW-1:0] idx;
  logic inrange;
  logic [RW-1:0] rcl;
  logic [CW-1:0] ccl;

  always_comb begin
    rcl = (rows_cfg == '0) ? RW'(1) :
          (32'(rows_cfg) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(rows_cfg);
    ccl = (cols_cfg == '0) ? CW'(1) :
          (32'(cols_cfg) > MAX_COLS) ? CW'(MAX_COLS) : CW'(cols_cfg);
  end

  assign idx     = LW'(bot_r) * LW'(cols_r) + LW'(c_r);
  assign inrange = idx < LW'(CAP);
  // release the request only when the result transfers
  assign req_take = (st_r == S_DONE) && res_take;
  assign res_sum  = best_r[SUM_BITS-1:0];
  assign res_valid = (st_r == S_DONE);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (st_r == S_ACC) colacc[c_r[CIW-1:0]] <= col_s;
    acc_rd_r <= colacc[c_r[CIW-1:0]];
  end

  // top row clears the accumulator: first row pair loads instead of adds
  always_comb begin
    col_s = ((bot_r == top_r) ? BW'(0) : acc_rd_r)
          + (inrange ? BW'(rd_r) : BW'(0));
    run_s = run_r + col_s;
    if (run_s < 0) run_s = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      best_r <= '0;
    end else begin
      case (st_r)
        S_IDLE: if (req_valid) begin
          rows_r <= rcl; cols_r <= ccl;
          top_r <= '0; bot_r <= '0; c_r <= '0; run_r <= '0;
          best_r <= '0;
          st_r <= S_READ;
        end
        S_READ: st_r <= S_ACC;
        S_ACC: begin
          if (run_s > best_r) best_r <= run_s;
          run_r <= run_s;
          if (c_r + 1'b1 == cols_r) st_r <= S_NEXT;
          else begin
            c_r <= c_r + 1'b1;
            st_r <= S_READ;
          end
        end
        S_NEXT: begin
          c_r <= '0; run_r <= '0;
          if (bot_r + 1'b1 < rows_r) begin
            bot_r <= bot_r + 1'b1; st_r <= S_READ;
          end else if (top_r + 1'b1 < rows_r) begin
            top_r <= top_r + 1'b1; bot_r <= top_r + 1'b1; st_r <= S_READ;
          end else st_r <= S_DONE;
        end
        S_DONE: if (res_take) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/max_subrectangle_sum.sv =====
// Top level of the maximum subrectangle sum block.
`default_nettype none
// Cells load one per cycle into a grid memory while the input is not full. The
// cell marked last starts a search that steps over every top/bottom row pair
// and every column, with a memory read step and then an accumulate step per
// column plus a next step per row pair; during it and until the result is
// popped the input stays full. The single result then waits until popped.
// Cells beyond the memory capacity are dropped.
module max_subrectangle_sum #(
  parameter int MAX_ROWS   = msub_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = msub_pkg::MAX_COLS_DEF,
  parameter int VALUE_BITS = msub_pkg::VALUE_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_push,
  output logic                                       in_full,
  input  wire logic signed [msub_pkg::CELL_BITS-1:0] in_cell_value,
  input  wire logic                                  in_last_cell,
  output logic                                       out_empty,
  input  wire logic                                  out_pop,
  output logic [msub_pkg::SUM_BITS-1:0]              out_best_sum,
  input  wire logic                                  cfg_we,
  input  wire logic                                  cfg_index,
  input  wire logic [msub_pkg::CFG_BITS-1:0]         cfg_data
);
  import msub_pkg::*;
  localparam int CAP = MAX_ROWS * MAX_COLS;
  localparam int AW  = (CAP > 1) ? $clog2(CAP) : 1;

  logic [CFG_BITS-1:0] rows_r, cols_r;
  logic wr_en, req_valid, req_take, res_valid;
  logic [AW-1:0] wr_addr;
  logic signed [VALUE_BITS-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= CFG_BITS'(REG_ROW_COUNT_RESET);
      cols_r <= CFG_BITS'(REG_COL_COUNT_RESET);
    end else if (cfg_we) begin
      if (cfg_index == 1'(IDX_ROW_COUNT)) rows_r <= cfg_data;
      else cols_r <= cfg_data;
    end
  end

  msub_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .VALUE_BITS(VALUE_BITS),
               .CAP(CAP), .AW(AW)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_cell_value, .in_last_cell,
    .wr_en, .wr_addr, .wr_data, .req_valid, .req_take);

  msub_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .VALUE_BITS(VALUE_BITS),
              .CAP(CAP), .AW(AW)) u_back (
    .clk, .rst_n, .wr_en, .wr_addr, .wr_data, .req_valid, .req_take,
    .rows_cfg(rows_r), .cols_cfg(cols_r), .res_valid, .res_sum(out_best_sum),
    .res_take(out_pop));

  assign out_empty = !res_valid;
endmodule
`default_nettype wire

// ===== rtl/max_subrectangle_sum_chk.sv =====
// Port-level checker for the maximum subrectangle sum block, with its bind.
`default_nettype none
module max_subrectangle_sum_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_push,
  input wire logic        in_full,
  input wire logic        in_last_cell,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic [26:0] out_best_sum
);
  a_last_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_push && !in_full && in_last_cell |=> in_full) else $error("no stall after last");
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_best_sum))
    else $error("result dropped");
  a_full_res: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> in_full) else $error("input open during result");
  a_rst: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("reset state");
endmodule

bind max_subrectangle_sum max_subrectangle_sum_chk u_chk (
  .clk, .rst_n, .in_push, .in_full, .in_last_cell, .out_empty, .out_pop,
  .out_best_sum);
`default_nettype wire

// ===== tb/msub_checker.sv =====
// Checker for max_subrectangle_sum: watches the ports, predicts best sums, compares.
`timescale 1ns / 100ps
module msub_checker (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_push,
  input  wire logic                                  in_full,
  input  wire logic signed [msub_pkg::CELL_BITS-1:0] in_cell_value,
  input  wire logic                                  in_last_cell,
  input  wire logic                                  out_empty,
  input  wire logic                                  out_pop,
  input  wire logic [msub_pkg::SUM_BITS-1:0]         out_best_sum,
  input  wire logic                                  cfg_we,
  input  wire logic                                  cfg_index,
  input  wire logic [msub_pkg::CFG_BITS-1:0]         cfg_data,
  output int                                         fail_count,
  output int                                         pending,
  output int                                         result_count
);
  localparam int CAPACITY = msub_pkg::MAX_ROWS_DEF * msub_pkg::MAX_COLS_DEF;

  longint                            grid_cells [CAPACITY];
  int                                load_ptr;
  logic [msub_pkg::CFG_BITS-1:0]     row_reg;
  logic [msub_pkg::CFG_BITS-1:0]     col_reg;
  logic [msub_pkg::SUM_BITS-1:0]     best_sums [$];

  function automatic int eff_dim(input logic [msub_pkg::CFG_BITS-1:0] v, input int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  // Top row fixed, lower rows folded into column sums, zero-clamped column scan.
  function automatic logic [msub_pkg::SUM_BITS-1:0] best_rectangle();
    longint col_acc [msub_pkg::MAX_COLS_DEF];
    longint run;
    longint best;
    int     rows;
    int     cols;
    int     idx;
    rows = eff_dim(row_reg, msub_pkg::MAX_ROWS_DEF);
    cols = eff_dim(col_reg, msub_pkg::MAX_COLS_DEF);
    best = 0;
    for (int top = 0; top < rows; top++) begin
      for (int c = 0; c < msub_pkg::MAX_COLS_DEF; c++) col_acc[c] = 0;
      for (int bot = top; bot < rows; bot++) begin
        run = 0;
        for (int c = 0; c < cols; c++) begin
          idx = bot * cols + c;
          if (idx < CAPACITY) col_acc[c] += grid_cells[idx];
          run += col_acc[c];
          if (run < 0) run = 0;
          if (run > best) best = run;
        end
      end
    end
    return best[msub_pkg::SUM_BITS-1:0];
  endfunction

  initial begin
    fail_count   = 0;
    result_count = 0;
    pending      = 0;
    load_ptr     = 0;
    row_reg      = msub_pkg::CFG_BITS'(msub_pkg::REG_ROW_COUNT_RESET);
    col_reg      = msub_pkg::CFG_BITS'(msub_pkg::REG_COL_COUNT_RESET);
    for (int i = 0; i < CAPACITY; i++) grid_cells[i] = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_index == 1'(msub_pkg::IDX_ROW_COUNT)) row_reg <= cfg_data;
        else col_reg <= cfg_data;
      end
      if (in_push && !in_full) begin
        if (load_ptr < CAPACITY) begin
          grid_cells[load_ptr] = longint'(in_cell_value);
          load_ptr++;
        end
        if (in_last_cell) begin
          best_sums.push_back(best_rectangle());
          load_ptr = 0;
        end
      end
      if (out_pop && !out_empty) begin
        result_count++;
        if (best_sums.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: unexpected result best_sum=%0d", out_best_sum);
        end else begin
          if (out_best_sum !== best_sums[0]) begin
            fail_count++;
            if (fail_count <= 10)
              $display("ERROR: best_sum expected %0d got %0d", best_sums[0], out_best_sum);
          end
          void'(best_sums.pop_front());
        end
      end
      pending = best_sums.size();
    end
  end
endmodule

// ===== tb/tb_max_subrectangle_sum.sv =====
// Testbench top for max_subrectangle_sum: stimulus, pressure phases and verdict.
`timescale 1ns / 100ps
module tb_max_subrectangle_sum;
  logic                                  clk;
  logic                                  rst_n;
  logic                                  in_push;
  logic signed [msub_pkg::CELL_BITS-1:0] in_cell_value;
  logic                                  in_last_cell;
  logic                                  out_pop;
  logic                                  cfg_we;
  logic                                  cfg_index;
  logic [msub_pkg::CFG_BITS-1:0]         cfg_data;
  logic                                  in_full;
  logic                                  out_empty;
  logic [msub_pkg::SUM_BITS-1:0]         out_best_sum;
  int                                    fail_count;
  int                                    pending;
  int                                    result_count;
  int                                    cells_sent;
  int                                    grids_sent;
  bit                                    no_idle;
  bit                                    hold_req;

  max_subrectangle_sum u_dut (
    .clk, .rst_n, .in_push, .in_full, .in_cell_value, .in_last_cell,
    .out_empty, .out_pop, .out_best_sum, .cfg_we, .cfg_index, .cfg_data
  );

  msub_checker u_checker (
    .clk, .rst_n, .in_push, .in_full, .in_cell_value, .in_last_cell,
    .out_empty, .out_pop, .out_best_sum, .cfg_we, .cfg_index, .cfg_data,
    .fail_count, .pending, .result_count
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("max_subrectangle_sum verification failed");
    $finish;
  end

  function automatic logic signed [msub_pkg::CELL_BITS-1:0] random_cell();
    case ($urandom_range(0, 5))
      0:       return 16'sh7fff;
      1:       return -16'sh8000;
      2, 3:    return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  function automatic int eff_dim(input int v);
    if (v == 0) return 1;
    if (v > 64) return 64;
    return v;
  endfunction

  // Called at a clock edge; returns at the edge where the transfer happened.
  task automatic send_cell(input logic signed [msub_pkg::CELL_BITS-1:0] v, input logic l);
    int gap;
    bit done;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    done = 0;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push       <= 1'b1;
    in_cell_value <= v;
    in_last_cell  <= l;
    while (!done) begin
      @(negedge clk);
      if (!in_full) done = 1;
      @(posedge clk);
    end
    cells_sent++;
  endtask

  task automatic send_grid(input int n);
    for (int i = 1; i <= n; i++) send_cell(random_cell(), i == n);
    grids_sent++;
  endtask

  // Drop push, wait for every result, then let the search machinery settle.
  task automatic wait_idle();
    in_push <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_dims(input int r, input int c);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= 1'(msub_pkg::IDX_ROW_COUNT);
    cfg_data  <= 7'(r);
    @(posedge clk);
    cfg_index <= 1'(msub_pkg::IDX_COL_COUNT);
    cfg_data  <= 7'(c);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Result side: random pop gaps, plus a long hold-off on request.
  initial begin
    int gap;
    bit done;
    out_pop = 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_pop <= 1'b0;
        repeat (3000) @(posedge clk);
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 12);
        done = 0;
        if (gap > 0) begin
          out_pop <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_pop <= 1'b1;
        while (!done) begin
          @(negedge clk);
          if (!out_empty) done = 1;
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    int r;
    int c;
    int n;
    int phase;
    int k;
    int big [5] = '{0, 1, 64, 100, 127};
    rst_n         = 1'b0;
    in_push       = 1'b0;
    in_cell_value = '0;
    in_last_cell  = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = 1'b0;
    cfg_data      = '0;
    cells_sent    = 0;
    grids_sent    = 0;
    no_idle       = 0;
    hold_req      = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: single-cell extremes, zero register, small grids.
    set_dims(1, 1);
    send_cell(16'sh7fff, 1'b1);
    send_cell(-16'sh8000, 1'b1);
    set_dims(0, 0);
    send_cell(16'sd5, 1'b1);
    set_dims(2, 3);
    send_cell(16'sh7fff, 1'b0); send_cell(-16'sh8000, 1'b0); send_cell(16'sh7fff, 1'b0);
    send_cell(-16'sd1, 1'b0);   send_cell(16'sh7fff, 1'b0);  send_cell(16'sh7fff, 1'b1);
    send_cell(-16'sd3, 1'b0);   send_cell(-16'sd7, 1'b1);    // early last cell
    set_dims(1, 2);
    send_cell(16'sd9, 1'b0); send_cell(-16'sd2, 1'b0);
    send_cell(16'sd100, 1'b0); send_cell(16'sd4, 1'b1);      // extra cells
    set_dims(127, 1);
    send_grid(64);

    // Write every entry that any later grid can read, so short grids see old data.
    set_dims(1, 1);
    no_idle = 1;
    send_grid(130);
    no_idle = 0;

    phase = 0;
    while (cells_sent < 1100) begin
      k = $urandom_range(0, 9);
      if (k == 0) begin
        r = big[$urandom_range(0, 4)]; c = $urandom_range(0, 2);
      end else if (k == 1) begin
        c = big[$urandom_range(0, 4)]; r = $urandom_range(0, 2);
      end else begin
        r = $urandom_range(1, 8); c = $urandom_range(1, 8);
      end
      if (phase == 1) begin
        r = 1; c = 2;
      end
      set_dims(r, c);
      no_idle = ($urandom_range(0, 4) == 0);
      if (phase == 1) hold_req = 1;
      n = eff_dim(r) * eff_dim(c);
      for (int g = 0; g < ((phase == 1) ? 8 : 3); g++) begin
        case ($urandom_range(0, 9))
          0:       send_grid(n + $urandom_range(1, 5));
          1:       send_grid($urandom_range(1, n));
          default: send_grid(n);
        endcase
      end
      phase++;
    end

    wait_idle();
    repeat (50) @(posedge clk);
    $display("Covered %0d cells in %0d grids over %0d register settings, %0d results checked.",
             cells_sent, grids_sent, phase + 6, result_count);
    if (fail_count == 0) begin
      $display("max_subrectangle_sum verification clean");
    end else begin
      $display("max_subrectangle_sum verification failed");
    end
    $finish;
  end
endmodule
